@@ src/mtr_pkg.sv @@
// Shared types and constants for the two-engine MIDI router.
// Holds the message decode codes, destination codes and the bank test.
// No dependencies.
package mtr_pkg;

  localparam int NOTES  = 128;
  localparam int NOTE_W = 7;

  localparam logic [3:0] OP_NOTE_OFF = 4'h8;
  localparam logic [3:0] OP_NOTE_ON  = 4'h9;
  localparam logic [3:0] OP_CTRL     = 4'hB;
  localparam logic [3:0] OP_SYSTEM   = 4'hF;

  localparam logic [6:0] CC_BANK_MSB   = 7'd0;
  localparam logic [6:0] CC_BANK_LSB   = 7'd32;
  localparam logic [6:0] CC_SUSTAIN    = 7'd64;
  localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
  localparam logic [6:0] SUSTAIN_ON_MIN = 7'd64;

  localparam logic [6:0] BANK_ALT_A = 7'd33;
  localparam logic [6:0] BANK_ALT_B = 7'd81;
  localparam logic [6:0] BANK_ALT_C = 7'd97;

  localparam logic [1:0] DEST_PRIM = 2'd0;
  localparam logic [1:0] DEST_ALT  = 2'd1;
  localparam logic [1:0] DEST_BOTH = 2'd2;

  function automatic logic bank_is_alt(logic [6:0] v);
    return (v == BANK_ALT_A) || (v == BANK_ALT_B) || (v == BANK_ALT_C);
  endfunction

endpackage

@@ src/mtr_count_mem.sv @@
// Single-port note count memory with a registered, read-first output.
// Holds both engines' counts side by side in one word. No dependencies.
module mtr_count_mem #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/midi_two_engine_router_unit.sv @@
// Top level of the two-engine MIDI router: decode, sequencer and state.
// Depends on mtr_pkg and mtr_count_mem.
// Reset clears bank and sustain state at once; ST_CLR_ALL then zeroes the whole count memory.
// A non-channel word goes from ST_IDLE straight to ST_OUT; a note or controller word
// passes ST_ISSUE and ST_RD; an all-notes clear passes ST_ISSUE, ST_SCAN over the
// channel's 128 entries and ST_SCAN_END. Input stalls until ST_OUT registers the result.
module midi_two_engine_router_unit
  import mtr_pkg::*;
#(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_status_byte,
  input  logic [6:0] in_first_data,
  input  logic [6:0] in_second_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_destination
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * NOTES;
  localparam int ADDR_W = CH_W + NOTE_W;
  localparam int DATA_W = 2 * COUNT_BITS;

  typedef enum logic [2:0] {
    ST_CLR_ALL, ST_IDLE, ST_ISSUE, ST_RD, ST_SCAN, ST_SCAN_END, ST_OUT
  } state_t;

  state_t                state_r;
  logic [7:0]            status_r;
  logic [6:0]            d1_r;
  logic [6:0]            d2_r;
  logic [6:0]            bank_r [CHANNELS];
  logic [CHANNELS-1:0]   alt_sus_r;
  logic [CHANNELS-1:0]   prim_sus_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic [NOTE_W-1:0]     scan_n_r;
  logic                  scan_vld_r;
  logic                  any_alt_r;
  logic                  any_prim_r;
  logic [1:0]            dest_r;
  logic                  out_valid_r;
  logic [1:0]            out_dest_r;

  logic [3:0]            op;
  logic [CH_W-1:0]       ch;
  logic                  is_ctrl, note_on, note_off, sus, sus_off, clears;
  logic                  bank_wr, bank_sel, was_alt, is_alt;
  logic [6:0]            bank_new;
  logic [COUNT_BITS-1:0] rd_alt, rd_prim, alt_new, prim_new;
  logic                  alt_nz, prim_nz, alt_rel, prim_rel;
  logic [1:0]            dest_calc;
  logic                  in_chan_msg;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [DATA_W-1:0]     mem_wdata;
  logic [DATA_W-1:0]     mem_rdata;

  assign op      = status_r[7:4];
  assign ch      = status_r[CH_W-1:0];
  assign is_ctrl = (op == OP_CTRL);
  assign note_on  = (op == OP_NOTE_ON) && (d2_r != 7'd0);
  assign note_off = (op == OP_NOTE_OFF) || ((op == OP_NOTE_ON) && (d2_r == 7'd0));
  assign sus      = is_ctrl && (d1_r == CC_SUSTAIN);
  assign sus_off  = sus && (d2_r < SUSTAIN_ON_MIN);
  assign clears   = is_ctrl && ((d1_r == CC_SOUND_OFF) || (d1_r == CC_NOTES_OFF));
  assign bank_wr  = is_ctrl && (d1_r == CC_BANK_MSB);
  assign bank_sel = bank_wr || (is_ctrl && (d1_r == CC_BANK_LSB));
  assign bank_new = bank_wr ? d2_r : bank_r[ch];
  assign was_alt  = bank_is_alt(bank_r[ch]);
  assign is_alt   = bank_is_alt(bank_new);

  assign rd_alt  = mem_rdata[DATA_W-1:COUNT_BITS];
  assign rd_prim = mem_rdata[COUNT_BITS-1:0];
  assign alt_nz  = (rd_alt != '0);
  assign prim_nz = (rd_prim != '0);

  assign alt_rel = clears ? (any_alt_r || alt_nz || alt_sus_r[ch])
                          : ((note_off && alt_nz) || (sus_off && alt_sus_r[ch]));
  assign prim_rel = clears ? (any_prim_r || prim_nz || prim_sus_r[ch])
                           : ((note_off && prim_nz) || (sus_off && prim_sus_r[ch]));

  always_comb begin
    if (bank_sel && was_alt && !is_alt) begin
      dest_calc = DEST_BOTH;
    end else if (!is_alt && alt_rel) begin
      dest_calc = DEST_BOTH;
    end else if (is_alt && prim_rel) begin
      dest_calc = DEST_BOTH;
    end else begin
      dest_calc = is_alt ? DEST_ALT : DEST_PRIM;
    end
  end

  always_comb begin
    alt_new  = rd_alt;
    prim_new = rd_prim;
    if (note_on) begin
      if (is_alt && (rd_alt != '1)) begin
        alt_new = rd_alt + COUNT_BITS'(1);
      end
      if (!is_alt && (rd_prim != '1)) begin
        prim_new = rd_prim + COUNT_BITS'(1);
      end
    end else if (note_off) begin
      if (alt_nz) begin
        alt_new = rd_alt - COUNT_BITS'(1);
      end
      if (prim_nz) begin
        prim_new = rd_prim - COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {ch, d1_r};
    mem_wdata = {alt_new, prim_new};
    case (state_r)
      ST_CLR_ALL: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      ST_RD: begin
        mem_we = note_on || note_off;
      end
      ST_SCAN: begin
        mem_we    = 1'b1;
        mem_addr  = {ch, scan_n_r};
        mem_wdata = '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_chan_msg = in_status_byte[7] && (in_status_byte[7:4] != OP_SYSTEM)
                       && ({1'b0, in_status_byte[3:0]} < 5'(CHANNELS));

  mtr_count_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W),
    .DATA_W(DATA_W)
  ) u_count_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .addr   (mem_addr),
    .wr_data(mem_wdata),
    .rd_data(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR_ALL;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      alt_sus_r   <= '0;
      prim_sus_r  <= '0;
      scan_vld_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        bank_r[i] <= 7'd0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR_ALL: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            status_r <= in_status_byte;
            d1_r     <= in_first_data;
            d2_r     <= in_second_data;
            if (in_chan_msg) begin
              state_r <= ST_ISSUE;
            end else begin
              dest_r  <= DEST_PRIM;
              state_r <= ST_OUT;
            end
          end
        end
        ST_ISSUE: begin
          scan_n_r   <= '0;
          scan_vld_r <= 1'b0;
          any_alt_r  <= 1'b0;
          any_prim_r <= 1'b0;
          state_r    <= clears ? ST_SCAN : ST_RD;
        end
        ST_RD: begin
          dest_r <= dest_calc;
          if (bank_wr) begin
            bank_r[ch] <= d2_r;
          end
          if (sus) begin
            if (sus_off) begin
              alt_sus_r[ch]  <= 1'b0;
              prim_sus_r[ch] <= 1'b0;
            end else if (is_alt) begin
              alt_sus_r[ch] <= 1'b1;
            end else begin
              prim_sus_r[ch] <= 1'b1;
            end
          end
          state_r <= ST_OUT;
        end
        ST_SCAN: begin
          scan_vld_r <= 1'b1;
          if (scan_vld_r) begin
            any_alt_r  <= any_alt_r || alt_nz;
            any_prim_r <= any_prim_r || prim_nz;
          end
          scan_n_r <= scan_n_r + NOTE_W'(1);
          if (scan_n_r == NOTE_W'(NOTES - 1)) begin
            state_r <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          dest_r  <= dest_calc;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_dest_r  <= dest_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_destination = out_dest_r;

endmodule

@@ src/mtr_checker.sv @@
// Port-level assertions for the two-engine MIDI router, bound to the top level.
// Depends on mtr_pkg and midi_two_engine_router_unit.
module mtr_checker
  import mtr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_destination
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("Input taken right after reset.");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Second word accepted while one is in work.");

  a_dest_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_destination == DEST_PRIM || out_destination == DEST_ALT
                   || out_destination == DEST_BOTH))
    else $error("Result word carries an unused destination code.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_destination)))
    else $error("Stalled result word changed.");

endmodule

bind midi_two_engine_router_unit mtr_checker u_mtr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_destination(out_destination)
);
